[src/joint_orientation_frame_assert.svh]
// Assertion macros shared by the joint orientation frame RTL.
`ifndef JOINT_ORIENTATION_FRAME_ASSERT_SVH
`define JOINT_ORIENTATION_FRAME_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define JOF_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Implication checked in the cycle after the condition.
`define JOF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

[src/jof_pkg.sv]
// Package: types, constants and joint rule table for the joint orientation frame.
`timescale 1ns / 1ps
package jof_pkg;

	localparam int JointCount = 20;
	localparam int PosFracBits = 12;
	localparam int IdxW = 5;
	localparam int PosW = 16;
	localparam logic signed [15:0] OneQ14 = 16'sd16384;

	typedef enum logic [2:0] {
		M_X  = 3'd0,
		M_Y  = 3'd1,
		M_Z  = 3'd2,
		M_XY = 3'd3,
		M_YX = 3'd4,
		M_YZ = 3'd5
	} mode_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                   command;
		logic [IdxW-1:0]        joint_index;
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [PosW-1:0] pos_z;
		logic                   tracked;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] xaxis_x;
		logic signed [15:0] xaxis_y;
		logic signed [15:0] xaxis_z;
		logic signed [15:0] yaxis_x;
		logic signed [15:0] yaxis_y;
		logic signed [15:0] yaxis_z;
		logic signed [15:0] zaxis_x;
		logic signed [15:0] zaxis_y;
		logic signed [15:0] zaxis_z;
		logic               valid_res;
	} out_req_t;

	// Queue entry from the front end: the query, already classified.
	typedef struct packed {
		logic            tracked;
		mode_t           mode;
		logic [IdxW-1:0] am;
		logic [IdxW-1:0] as_;
		logic [IdxW-1:0] bm;
		logic [IdxW-1:0] bs;
	} job_t;

	typedef struct packed {
		mode_t           mode;
		logic [IdxW-1:0] am;
		logic [IdxW-1:0] as_;
		logic [IdxW-1:0] bm;
		logic [IdxW-1:0] bs;
	} rule_t;

	function automatic rule_t rule_lookup(input logic [IdxW-1:0] j);
		rule_t r;
		case (j)
			5'd0:  r = '{M_YX, 5'd16, 5'd12, 5'd1,  5'd0};
			5'd1:  r = '{M_YX, 5'd8,  5'd4,  5'd2,  5'd1};
			5'd2:  r = '{M_YX, 5'd8,  5'd4,  5'd3,  5'd2};
			5'd3:  r = '{M_Y,  5'd3,  5'd2,  5'd0,  5'd0};
			5'd4:  r = '{M_XY, 5'd4,  5'd5,  5'd6,  5'd5};
			5'd5:  r = '{M_XY, 5'd5,  5'd6,  5'd4,  5'd5};
			5'd6:  r = '{M_X,  5'd6,  5'd7,  5'd0,  5'd0};
			5'd7:  r = '{M_X,  5'd6,  5'd7,  5'd0,  5'd0};
			5'd8:  r = '{M_XY, 5'd9,  5'd8,  5'd10, 5'd9};
			5'd9:  r = '{M_XY, 5'd10, 5'd9,  5'd8,  5'd9};
			5'd10: r = '{M_X,  5'd11, 5'd10, 5'd0,  5'd0};
			5'd11: r = '{M_X,  5'd11, 5'd10, 5'd0,  5'd0};
			5'd12: r = '{M_YX, 5'd16, 5'd12, 5'd12, 5'd13};
			5'd13: r = '{M_YZ, 5'd13, 5'd14, 5'd14, 5'd15};
			5'd14: r = '{M_Z,  5'd14, 5'd15, 5'd0,  5'd0};
			5'd15: r = '{M_Z,  5'd14, 5'd15, 5'd0,  5'd0};
			5'd16: r = '{M_YX, 5'd16, 5'd12, 5'd16, 5'd17};
			5'd17: r = '{M_YZ, 5'd17, 5'd18, 5'd18, 5'd19};
			5'd18: r = '{M_Z,  5'd18, 5'd19, 5'd0,  5'd0};
			5'd19: r = '{M_Z,  5'd18, 5'd19, 5'd0,  5'd0};
			default: r = '{M_X, 5'd0, 5'd0, 5'd0, 5'd0};
		endcase
		return r;
	endfunction

endpackage

[src/jof_front.sv]
// Front end: takes requests, stores the tracked flag of joint loads, classifies queries into jobs.
`timescale 1ns / 1ps
module jof_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jof_pkg::in_req_t   in_data,
	output logic               job_valid,
	input  logic               job_ready,
	output jof_pkg::job_t      job,
	// high when no query is queued or being built
	input  logic               load_ok,
	// position write port toward the store in the back end
	output logic               wr_en,
	output logic [4:0]         wr_idx
);
	logic [jof_pkg::JointCount-1:0] trk_q;
	logic                           in_range;
	logic                           is_load;
	jof_pkg::rule_t                 rule;

	assign in_range = in_data.joint_index < 5'(jof_pkg::JointCount);
	assign is_load  = in_data.command == jof_pkg::CMD_LOAD;
	assign rule     = jof_pkg::rule_lookup(in_data.joint_index);

	// Loads wait until earlier queries have read the store; queries wait for queue room.
	assign in_ready  = is_load ? load_ok : job_ready;
	assign job_valid = in_valid && !is_load;
	assign wr_en     = in_valid && is_load && in_range && load_ok;
	assign wr_idx    = in_data.joint_index;

	always_comb begin
		job.mode = rule.mode;
		job.am   = rule.am;
		job.as_  = rule.as_;
		job.bm   = rule.bm;
		job.bs   = rule.bs;
		job.tracked = in_range && trk_q[in_data.joint_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '0;
		end else if (wr_en) begin
			trk_q[in_data.joint_index] <= in_data.tracked;
		end
	end
endmodule

[src/jof_queue.sv]
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
module jof_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  jof_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output jof_pkg::job_t rd_data
);
	jof_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`include "joint_orientation_frame_assert.svh"
	`JOF_ASSERT_IMP(a_q_no_over, clk, arst_n, cnt_q == 2'd2, !push)
	`JOF_ASSERT_IMP(a_q_no_under, clk, arst_n, cnt_q == 2'd0, !pop)
endmodule

[src/jof_back.sv]
// Back end: position store and a sequencer that builds the frame with shared units.
`timescale 1ns / 1ps
module jof_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mirror,
	input  logic               wr_en,
	input  logic [4:0]         wr_idx,
	input  logic signed [15:0] wr_x,
	input  logic signed [15:0] wr_y,
	input  logic signed [15:0] wr_z,
	input  logic               job_valid,
	output logic               job_ready,
	input  jof_pkg::job_t      job,
	output logic               idle,
	output logic               out_valid,
	input  logic               out_ready,
	output jof_pkg::out_req_t  out_data
);
	typedef enum logic [4:0] {
		S_IDLE, S_RDA, S_DA, S_RDB, S_DB,
		S_U1, S_U2, S_T1, S_U3, S_X1, S_X2, S_U4, S_C1, S_C2, S_DONE,
		S_NSCL, S_NSQ, S_NSQRT, S_NDIV
	} st_t;

	// position store: written once per load, reset value zero
	logic [47:0] pos_q [jof_pkg::JointCount];
	logic [jof_pkg::JointCount-1:0] pv_q;

	st_t  st_q, ret_q;
	jof_pkg::job_t job_q;
	logic signed [16:0] va_q [3];
	logic signed [16:0] vb_q [3];
	logic signed [15:0] x_q [3];
	logic signed [15:0] y_q [3];
	logic signed [15:0] z_q [3];
	logic signed [15:0] ca_q [3];
	logic signed [15:0] cb_q [3];
	logic signed [30:0] nv_q [3];  // vector to normalize
	logic [29:0]        mg_q [3];  // scaled magnitudes
	logic signed [15:0] nu_q [3];  // normalize result
	logic [62:0]        s_q;
	logic [31:0]        r_q;
	logic [62:0]        rem_q;
	logic [5:0]         cnt_q;
	logic [1:0]         ci_q;
	logic [44:0]        dn_q;
	logic [15:0]        dq_q;
	logic               rdm_q, rds_q;  // read selects: m then s
	logic [47:0]        pm_q;
	logic signed [30:0] cr_q [3];
	logic               ovld_q;
	jof_pkg::out_req_t  od_q;

	logic [4:0]  ridx;
	logic [47:0] rdata;
	logic        nz;

	assign job_ready = st_q == S_IDLE && !ovld_q;
	assign idle      = st_q == S_IDLE;
	assign out_valid = ovld_q;
	assign out_data  = od_q;

	always_comb begin
		case (st_q)
			S_RDA: ridx = rds_q ? job_q.as_ : job_q.am;
			S_RDB: ridx = rds_q ? job_q.bs : job_q.bm;
			default: ridx = job_q.am;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) pos_q[wr_idx] <= {wr_x, wr_y, wr_z};
	end
	always_ff @(posedge clk) begin
		rdata <= pv_q[ridx] ? pos_q[ridx] : 48'd0;
	end

	function automatic logic [29:0] mag31(input logic signed [30:0] v);
		logic [30:0] t;
		t = v[30] ? 31'(-v) : 31'(v);
		return t[29:0];
	endfunction

	function automatic logic signed [15:0] rnd14(input logic signed [30:0] v);
		logic [30:0] m;
		logic [16:0] q;
		m = v[30] ? 31'(-v) : 31'(v);
		q = 17'((m + 31'd8192) >> 14);
		if (q > 17'd16384) q = 17'd16384;
		return v[30] ? -16'(q) : 16'(q);
	endfunction

	logic [29:0] mmax;
	assign mmax = (mg_q[0] | mg_q[1]) | mg_q[2];
	assign nz   = mmax != 30'd0;

	logic [60:0] sq;
	assign sq = 61'(mg_q[ci_q]) * 61'(mg_q[ci_q]);

	logic signed [31:0] pa, pb;
	// cross products a x b, one component per cycle
	logic [1:0] i1, i2;
	always_comb begin
		case (ci_q)
			2'd0: begin i1 = 2'd1; i2 = 2'd2; end
			2'd1: begin i1 = 2'd2; i2 = 2'd0; end
			default: begin i1 = 2'd0; i2 = 2'd1; end
		endcase
	end
	assign pa = ca_q[i1] * cb_q[i2];
	assign pb = ca_q[i2] * cb_q[i1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ret_q  <= S_IDLE;
			ovld_q <= 1'b0;
			pv_q   <= '0;
			rds_q  <= 1'b0;
			rdm_q  <= 1'b0;
			cnt_q  <= '0;
			ci_q   <= '0;
		end else begin
			if (wr_en) pv_q[wr_idx] <= 1'b1;
			if (ovld_q && out_ready) ovld_q <= 1'b0;
			case (st_q)
				S_IDLE: if (job_valid && job_ready) begin
					job_q <= job;
					rds_q <= 1'b0;
					st_q  <= job.tracked ? S_RDA : S_DONE;
					for (int i = 0; i < 3; i++) begin
						x_q[i] <= (i == 0) ? jof_pkg::OneQ14 : 16'sd0;
						y_q[i] <= (i == 1) ? jof_pkg::OneQ14 : 16'sd0;
						z_q[i] <= (i == 2) ? jof_pkg::OneQ14 : 16'sd0;
					end
				end
				S_RDA, S_RDB: begin
					// read issued; data arrives next cycle
					rdm_q <= rds_q;
					st_q  <= st_q == S_RDA ? S_DA : S_DB;
				end
				S_DA, S_DB: begin
					if (!rdm_q) begin
						pm_q  <= rdata;
						rds_q <= 1'b1;
						st_q  <= st_q == S_DA ? S_RDA : S_RDB;
					end else begin
						for (int i = 0; i < 3; i++) begin
							if (st_q == S_DA)
								va_q[i] <= 17'(signed'(pm_q[47-16*i -: 16]))
									- 17'(signed'(rdata[47-16*i -: 16]));
							else
								vb_q[i] <= 17'(signed'(pm_q[47-16*i -: 16]))
									- 17'(signed'(rdata[47-16*i -: 16]));
						end
						rds_q <= 1'b0;
						st_q  <= st_q == S_DA ? S_RDB : S_U1;
					end
				end
				// normalize va (or vb for YX)
				S_U1: begin
					for (int i = 0; i < 3; i++)
						nv_q[i] <= job_q.mode == jof_pkg::M_YX ? 31'(vb_q[i]) : 31'(va_q[i]);
					ret_q <= S_U2;
					st_q  <= S_NSCL;
				end
				S_U2: begin
					case (job_q.mode)
						jof_pkg::M_X, jof_pkg::M_XY: for (int i = 0; i < 3; i++) x_q[i] <= nu_q[i];
						jof_pkg::M_Z: for (int i = 0; i < 3; i++) z_q[i] <= nu_q[i];
						default: for (int i = 0; i < 3; i++) y_q[i] <= nu_q[i];
					endcase
					if (job_q.mode == jof_pkg::M_X) begin
						nv_q[0] <= '0;
						nv_q[1] <= 31'(nu_q[2]);
						nv_q[2] <= -31'(nu_q[1]);
						ret_q <= S_T1;
						st_q  <= S_NSCL;
					end else if (job_q.mode == jof_pkg::M_Y || job_q.mode == jof_pkg::M_Z) begin
						nv_q[0] <= 31'(nu_q[1]);
						nv_q[1] <= -31'(nu_q[0]);
						nv_q[2] <= '0;
						ret_q <= S_T1;
						st_q  <= S_NSCL;
					end else begin
						for (int i = 0; i < 3; i++)
							nv_q[i] <= job_q.mode == jof_pkg::M_YX ? 31'(va_q[i]) : 31'(vb_q[i]);
						ret_q <= S_U3;
						st_q  <= S_NSCL;
					end
				end
				S_T1: begin
					// single-vector modes: second axis then final cross
					for (int i = 0; i < 3; i++) begin
						if (job_q.mode == jof_pkg::M_X) y_q[i] <= nu_q[i];
						else x_q[i] <= nu_q[i];
					end
					for (int i = 0; i < 3; i++) begin
						case (job_q.mode)
							jof_pkg::M_X: begin ca_q[i] <= x_q[i]; cb_q[i] <= nu_q[i]; end
							jof_pkg::M_Y: begin ca_q[i] <= nu_q[i]; cb_q[i] <= y_q[i]; end
							default: begin ca_q[i] <= z_q[i]; cb_q[i] <= nu_q[i]; end
						endcase
					end
					ci_q <= '0;
					st_q <= S_C1;
				end
				S_U3: begin
					for (int i = 0; i < 3; i++) begin
						case (job_q.mode)
							jof_pkg::M_XY: begin ca_q[i] <= x_q[i]; cb_q[i] <= nu_q[i]; end
							jof_pkg::M_YX: begin ca_q[i] <= nu_q[i]; cb_q[i] <= y_q[i]; end
							default: begin ca_q[i] <= y_q[i]; cb_q[i] <= nu_q[i]; end
						endcase
					end
					ci_q <= '0;
					st_q <= S_X1;
				end
				S_X1: begin
					cr_q[ci_q] <= 31'(pa - pb);
					if (ci_q == 2'd2) begin
						ci_q <= '0;
						st_q <= S_X2;
					end else ci_q <= ci_q + 2'd1;
				end
				S_X2: begin
					nv_q  <= cr_q;
					ret_q <= S_U4;
					st_q  <= S_NSCL;
				end
				S_U4: begin
					for (int i = 0; i < 3; i++) begin
						case (job_q.mode)
							jof_pkg::M_XY: begin
								z_q[i] <= nu_q[i]; ca_q[i] <= nu_q[i]; cb_q[i] <= x_q[i];
							end
							jof_pkg::M_YX: begin
								z_q[i] <= nu_q[i]; ca_q[i] <= y_q[i]; cb_q[i] <= nu_q[i];
							end
							default: begin
								x_q[i] <= nu_q[i]; ca_q[i] <= nu_q[i]; cb_q[i] <= y_q[i];
							end
						endcase
					end
					ci_q <= '0;
					st_q <= S_C1;
				end
				S_C1: begin
					cr_q[ci_q] <= 31'(pa - pb);
					if (ci_q == 2'd2) st_q <= S_C2;
					else ci_q <= ci_q + 2'd1;
				end
				S_C2: begin
					for (int i = 0; i < 3; i++) begin
						case (job_q.mode)
							jof_pkg::M_X, jof_pkg::M_Y, jof_pkg::M_YZ: z_q[i] <= rnd14(cr_q[i]);
							jof_pkg::M_YX: x_q[i] <= rnd14(cr_q[i]);
							default: y_q[i] <= rnd14(cr_q[i]);
						endcase
					end
					st_q <= S_DONE;
				end
				S_DONE: if (!ovld_q) begin
					od_q.xaxis_x <= x_q[0];
					od_q.xaxis_y <= (mirror && job_q.tracked) ? -x_q[1] : x_q[1];
					od_q.xaxis_z <= x_q[2];
					od_q.yaxis_x <= (mirror && job_q.tracked) ? -y_q[0] : y_q[0];
					od_q.yaxis_y <= y_q[1];
					od_q.yaxis_z <= (mirror && job_q.tracked) ? -y_q[2] : y_q[2];
					od_q.zaxis_x <= z_q[0];
					od_q.zaxis_y <= (mirror && job_q.tracked) ? -z_q[1] : z_q[1];
					od_q.zaxis_z <= z_q[2];
					od_q.valid_res <= job_q.tracked;
					ovld_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				// normalize unit: scale, sum of squares, sqrt, then divides
				S_NSCL: begin
					for (int i = 0; i < 3; i++) mg_q[i] <= mag31(nv_q[i]);
					cnt_q <= '0;
					st_q  <= S_NSQ;
					s_q   <= '0;
					ci_q  <= '0;
				end
				S_NSQ: begin
					if (!nz) begin
						for (int i = 0; i < 3; i++) nu_q[i] <= '0;
						st_q <= ret_q;
					end else if (!mmax[29]) begin
						for (int i = 0; i < 3; i++) mg_q[i] <= {mg_q[i][28:0], 1'b0};
					end else begin
						s_q <= s_q + 63'(sq);
						if (ci_q == 2'd2) begin
							ci_q  <= '0;
							cnt_q <= '0;
							r_q   <= '0;
							rem_q <= '0;
							st_q  <= S_NSQRT;
						end else ci_q <= ci_q + 2'd1;
					end
				end
				S_NSQRT: begin
					// sum is below 2^62: one result bit per cycle
					begin
						logic [62:0] rr;
						rr = {rem_q[60:0], s_q[61:60]};
						if (rr >= 63'({r_q[30:0], 2'b01})) begin
							rem_q <= rr - 63'({r_q[30:0], 2'b01});
							r_q   <= {r_q[30:0], 1'b1};
						end else begin
							rem_q <= rr;
							r_q   <= {r_q[30:0], 1'b0};
						end
					end
					s_q <= {s_q[60:0], 2'b00};
					if (cnt_q == 6'd30) begin
						cnt_q <= '0;
						ci_q  <= '0;
						st_q  <= S_NDIV;
					end else cnt_q <= cnt_q + 6'd1;
				end
				S_NDIV: begin
					// restoring divide, one quotient bit per cycle
					if (cnt_q == 6'd0) begin
						dn_q <= 45'({mg_q[ci_q], 14'd0}) + 45'(r_q >> 1);
						dq_q <= '0;
						rem_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						logic [45:0] nr;
						logic [15:0] qf;
						nr = {rem_q[44:0], dn_q[44]};
						qf = {dq_q[14:0], (nr >= 46'(r_q))};
						if (qf > 16'd16384) qf = 16'd16384;
						dn_q <= {dn_q[43:0], 1'b0};
						if (nr >= 46'(r_q)) begin
							rem_q <= 63'(nr - 46'(r_q));
							dq_q  <= {dq_q[14:0], 1'b1};
						end else begin
							rem_q <= 63'(nr);
							dq_q  <= {dq_q[14:0], 1'b0};
						end
						if (cnt_q == 6'd45) begin
							cnt_q <= '0;
							nu_q[ci_q] <= nv_q[ci_q][30] ? -16'(qf) : 16'(qf);
							if (ci_q == 2'd2) begin
								ci_q <= '0;
								st_q <= ret_q;
							end else ci_q <= ci_q + 2'd1;
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`include "joint_orientation_frame_assert.svh"
	`JOF_ASSERT_IMP(a_busy_no_take, clk, arst_n, st_q != S_IDLE, !job_ready)
	`JOF_ASSERT_NEXT(a_done_out, clk, arst_n, st_q == S_DONE && !ovld_q, ovld_q)
	`JOF_ASSERT_IMP(a_out_hold, clk, arst_n, ovld_q && !out_ready, !job_ready)
endmodule

[src/joint_orientation_frame.sv]
// Top level: joint store and orientation frame builder.
//  channel | dir | handshake              | payload
//  in      | in  | in_valid / in_ready    | in_data (in_req_t)
//  out     | out | out_valid / out_ready  | out_data (out_req_t)
//  cfg     | in  | cfg_we                 | cfg_wdata (mirror_axes)
// Loads wait while a query is queued or being built.
// A tracked query runs two or three normalizes, each with up to 29 shift steps,
// 3 squares, a 31-step square root and three divides. An untracked query goes
// from idle straight to the done state.
// Reset clears tracked flags, stored-position valid bits and mirror_axes.
// Queries queue two deep; a waiting result holds the back end, then the queue.
`timescale 1ns / 1ps
module joint_orientation_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jof_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output jof_pkg::out_req_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	logic          mirror_q;
	logic          jv, jr, qv, qr, wr_en;
	logic          bk_idle, ld_ok;
	logic [4:0]    wr_idx;
	jof_pkg::job_t jw, jq;

	assign ld_ok = !qv && bk_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mirror_q <= 1'b0;
		else if (cfg_we) mirror_q <= cfg_wdata;
	end

	jof_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(jv), .job_ready(jr), .job(jw), .load_ok(ld_ok), .wr_en, .wr_idx
	);
	jof_queue u_queue (
		.clk, .arst_n, .wr_valid(jv), .wr_ready(jr), .wr_data(jw),
		.rd_valid(qv), .rd_ready(qr), .rd_data(jq)
	);
	jof_back u_back (
		.clk, .arst_n, .mirror(mirror_q), .wr_en, .wr_idx,
		.wr_x(in_data.pos_x), .wr_y(in_data.pos_y), .wr_z(in_data.pos_z),
		.job_valid(qv), .job_ready(qr), .job(jq), .idle(bk_idle),
		.out_valid, .out_ready, .out_data
	);
endmodule

[test/tb_top.sv]
// Self-checking testbench for joint_orientation_frame: random skeletons, queries, mirror modes.
`timescale 1ns / 1ps
module tb_top;

	typedef int vec3_t[3];
	typedef longint wvec3_t[3];

	localparam int FrameCount = 48;
	localparam int DrainCycles = 60;
	localparam int LongHoldCycles = 4000;

	// neighbor table: mode, first difference (am - as), second difference (bm - bs)
	localparam jof_pkg::mode_t BONE_MODE [20] = '{jof_pkg::M_YX, jof_pkg::M_YX,
		jof_pkg::M_YX, jof_pkg::M_Y, jof_pkg::M_XY, jof_pkg::M_XY, jof_pkg::M_X,
		jof_pkg::M_X, jof_pkg::M_XY, jof_pkg::M_XY, jof_pkg::M_X, jof_pkg::M_X,
		jof_pkg::M_YX, jof_pkg::M_YZ, jof_pkg::M_Z, jof_pkg::M_Z, jof_pkg::M_YX,
		jof_pkg::M_YZ, jof_pkg::M_Z, jof_pkg::M_Z};
	localparam int BONE_AM [20] = '{16, 8, 8, 3, 4, 5, 6, 6, 9, 10, 11, 11, 16, 13, 14, 14, 16,
		17, 18, 18};
	localparam int BONE_AS [20] = '{12, 4, 4, 2, 5, 6, 7, 7, 8, 9, 10, 10, 12, 14, 15, 15, 12,
		18, 19, 19};
	localparam int BONE_BM [20] = '{1, 2, 3, 0, 6, 4, 0, 0, 10, 8, 0, 0, 12, 14, 0, 0, 16, 18,
		0, 0};
	localparam int BONE_BS [20] = '{0, 1, 2, 0, 5, 5, 0, 0, 9, 9, 0, 0, 13, 15, 0, 0, 17, 19,
		0, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	jof_pkg::in_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	jof_pkg::out_req_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	joint_orientation_frame DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	jof_pkg::in_req_t pending_reqs[$];
	jof_pkg::out_req_t expected_frames[$];
	int fails = 0;

	// model state
	int pos_store [20][3];
	bit trk_store [20];
	bit mirror_on = 1'b0;

	// traffic shaping
	int burst_left = 4;
	int gap_left = 0;
	bit send_hold = 1'b0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_cnt = 0;
	int stall_left = 0;

	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic vec3_t normalize(wvec3_t v);
		vec3_t u;
		longint unsigned mag[3], m, s, n, c;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (v[i] < 0) ? -v[i] : v[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			u = '{0, 0, 0};
			return u;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		s = 0;
		for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
		n = isqrt(s);
		for (int i = 0; i < 3; i++) begin
			c = ((mag[i] << 14) + n / 2) / n;
			if (c > 16384) c = 16384;
			u[i] = (v[i] < 0) ? -int'(c) : int'(c);
		end
		return u;
	endfunction

	function automatic wvec3_t cross_full(vec3_t a, vec3_t b);
		wvec3_t c;
		c[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
		c[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
		c[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
		return c;
	endfunction

	function automatic vec3_t cross_q14(vec3_t a, vec3_t b);
		wvec3_t r;
		vec3_t c;
		longint unsigned m;
		r = cross_full(a, b);
		for (int i = 0; i < 3; i++) begin
			m = (r[i] < 0) ? -r[i] : r[i];
			m = (m + 8192) >> 14;
			if (m > 16384) m = 16384;
			c[i] = (r[i] < 0) ? -int'(m) : int'(m);
		end
		return c;
	endfunction

	function automatic wvec3_t bone(int m, int s);
		wvec3_t v;
		for (int i = 0; i < 3; i++) v[i] = longint'(pos_store[m][i]) - pos_store[s][i];
		return v;
	endfunction

	function automatic jof_pkg::out_req_t frame_of(int j);
		jof_pkg::out_req_t f;
		vec3_t x, y, z, ub;
		wvec3_t t, va, vb;
		x = '{16384, 0, 0};
		y = '{0, 16384, 0};
		z = '{0, 0, 16384};
		f.valid_res = 1'b0;
		if (j < 20 && trk_store[j]) begin
			f.valid_res = 1'b1;
			va = bone(BONE_AM[j], BONE_AS[j]);
			vb = bone(BONE_BM[j], BONE_BS[j]);
			case (BONE_MODE[j])
				jof_pkg::M_X: begin
					x = normalize(va);
					t = '{0, x[2], -longint'(x[1])};
					y = normalize(t);
					z = cross_q14(x, y);
				end
				jof_pkg::M_Y: begin
					y = normalize(va);
					t = '{y[1], -longint'(y[0]), 0};
					x = normalize(t);
					z = cross_q14(x, y);
				end
				jof_pkg::M_Z: begin
					z = normalize(va);
					t = '{z[1], -longint'(z[0]), 0};
					x = normalize(t);
					y = cross_q14(z, x);
				end
				jof_pkg::M_XY: begin
					x = normalize(va);
					ub = normalize(vb);
					z = normalize(cross_full(x, ub));
					y = cross_q14(z, x);
				end
				jof_pkg::M_YX: begin
					y = normalize(vb);
					ub = normalize(va);
					z = normalize(cross_full(ub, y));
					x = cross_q14(y, z);
				end
				default: begin
					y = normalize(va);
					ub = normalize(vb);
					x = normalize(cross_full(y, ub));
					z = cross_q14(x, y);
				end
			endcase
			if (mirror_on) begin
				x[1] = -x[1];
				y[0] = -y[0];
				y[2] = -y[2];
				z[1] = -z[1];
			end
		end
		f.xaxis_x = 16'(x[0]); f.xaxis_y = 16'(x[1]); f.xaxis_z = 16'(x[2]);
		f.yaxis_x = 16'(y[0]); f.yaxis_y = 16'(y[1]); f.yaxis_z = 16'(y[2]);
		f.zaxis_x = 16'(z[0]); f.zaxis_y = 16'(z[1]); f.zaxis_z = 16'(z[2]);
		return f;
	endfunction

	function automatic void apply_request(jof_pkg::in_req_t r);
		if (r.command == jof_pkg::CMD_LOAD) begin
			if (r.joint_index < 20) begin
				pos_store[r.joint_index] = '{r.pos_x, r.pos_y, r.pos_z};
				trk_store[r.joint_index] = r.tracked;
			end
		end else
			expected_frames.push_back(frame_of(r.joint_index));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) apply_request(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_reqs.size() == 0 || send_hold) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else
						burst_left--;
				end
			end
		end
	end

	// receiver stall pattern, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_cnt = LongHoldCycles;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
		end
	end

	task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, $signed(e), $signed(a));
			fails++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				$error("frame with no query outstanding");
				fails++;
			end else begin
				jof_pkg::out_req_t e;
				e = expected_frames.pop_front();
				check_field("xaxis_x", e.xaxis_x, out_data.xaxis_x);
				check_field("xaxis_y", e.xaxis_y, out_data.xaxis_y);
				check_field("xaxis_z", e.xaxis_z, out_data.xaxis_z);
				check_field("yaxis_x", e.yaxis_x, out_data.yaxis_x);
				check_field("yaxis_y", e.yaxis_y, out_data.yaxis_y);
				check_field("yaxis_z", e.yaxis_z, out_data.yaxis_z);
				check_field("zaxis_x", e.zaxis_x, out_data.zaxis_x);
				check_field("zaxis_y", e.zaxis_y, out_data.zaxis_y);
				check_field("zaxis_z", e.zaxis_z, out_data.zaxis_z);
				if (e.valid_res !== out_data.valid_res) begin
					$error("valid_res: expected %0d, got %0d", e.valid_res, out_data.valid_res);
					fails++;
				end
			end
		end
	end

	function automatic jof_pkg::in_req_t mk(logic cmd, int idx, int x, int y, int z, logic t);
		jof_pkg::in_req_t r;
		r.command = cmd;
		r.joint_index = 5'(idx);
		r.pos_x = 16'(x);
		r.pos_y = 16'(y);
		r.pos_z = 16'(z);
		r.tracked = t;
		return r;
	endfunction

	function automatic int rand_coord(int k);
		case (k)
			0: return $signed(16'($urandom));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $signed(16'($urandom_range(0, 4095))) - 2048;
		endcase
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_mirror(bit v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_on = v;
	endtask

	// one skeleton frame of loads, then a handful of queries, with some noise
	task automatic queue_skeleton();
		int k, nq, base;
		k = $urandom_range(0, 5);
		base = $signed(16'($urandom));
		for (int j = 0; j < 20; j++) begin
			if (k == 3)
				pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, j, base, base, base, 1'b1));
			else
				pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, j, rand_coord(k % 3),
					rand_coord(k % 3), rand_coord(k % 3), $urandom_range(0, 9) != 0));
			if ($urandom_range(0, 15) == 0)
				pending_reqs.push_back(mk(1'($urandom_range(0, 1)), $urandom_range(20, 31),
					$signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
					1'($urandom_range(0, 1))));
		end
		nq = $urandom_range(4, 12);
		for (int q = 0; q < nq; q++)
			pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, $urandom_range(0, 19),
				$signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
				1'($urandom_range(0, 1))));
	endtask

	initial begin
		for (int j = 0; j < 20; j++) begin
			pos_store[j] = '{0, 0, 0};
			trk_store[j] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: never-loaded query, extremes, one joint per mode, out-of-range index
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b0));
		for (int j = 4; j <= 7; j++)
			pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, j, (j & 1) ? 32767 : -32768,
				(j & 2) ? -32768 : 32767, j * 1000 - 5000, 1'b1));
		for (int j = 13; j <= 15; j++)
			pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, j, j * 300, -j * 700, 32767 - j, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 2, 100, 200, 300, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 3, 100, 4296, 300, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 3, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 4, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 6, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 13, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 14, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 31, 1, 2, 3, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 31, -1, -1, -1, 1'b1));
		// zero vector: joint 7 onto joint 6
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 7, -32767, -32768, 2000, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 6, -32767, -32768, 2000, 1'b1));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 7, 0, 0, 0, 1'b0));
		// untracked
		pending_reqs.push_back(mk(jof_pkg::CMD_LOAD, 14, 5, 6, 7, 1'b0));
		pending_reqs.push_back(mk(jof_pkg::CMD_QUERY, 14, 0, 0, 0, 1'b0));
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			write_mirror(p[0] ^ 1'b1);
			no_idle = (p == 2);
			for (int f = 0; f < FrameCount / 4; f++) queue_skeleton();
			if (p == 1) begin
				// flood with queries while the receiver holds off
				for (int q = 0; q < 6; q++)
					pending_reqs.push_front(mk(jof_pkg::CMD_QUERY, q * 3, 0, 0, 0, 1'b0));
				hold_req = 1'b1;
			end
			if (p == 3) begin
				// sender pauses mid-phase until every frame is back
				while (pending_reqs.size() > 60) @(posedge clk);
				send_hold = 1'b1;
				while (expected_frames.size() != 0) @(posedge clk);
				send_hold = 1'b0;
			end
			wait_idle();
		end

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
